[design/qla_pkg.sv]
`default_nettype none

package qla_pkg;

   localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_SETMIN = 2'd1;
   localparam logic [1:0] CMD_SETMAX = 2'd2;
   localparam logic [1:0] CMD_REMOVE = 2'd3;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_DUP  = 2'd1;
   localparam logic [1:0] STATUS_FREE = 2'd2;

   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_DEFAULT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DEFAULT = 2'd1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [3:0]  slot;
      logic [3:0]  req_type;
      logic [31:0] limit_value;
   } req_item_type;

   typedef struct packed {
      logic [31:0] agg_value;
      logic [31:0] floor_now;
      logic [31:0] ceiling_now;
      logic [1:0]  status;
   } rsp_item_type;

   typedef struct packed {
      logic add;
      logic set_min;
      logic set_max;
      logic free;
   } tbl_cmd_type;

   typedef struct packed {
      logic        used;
      logic [3:0]  kind;
      logic [31:0] min_val;
      logic [31:0] max_val;
   } tbl_rd_type;

endpackage

`default_nettype wire

[design/qla_minmax.sv]
`default_nettype none

module qla_minmax (
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic             a_lt_b,
   output logic [31:0]      lesser
);

   assign a_lt_b = (a < b);
   assign lesser = a_lt_b ? a : b;

endmodule

`default_nettype wire

[design/qla_table.sv]
`default_nettype none

module qla_table #(
   parameter int SLOTS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire qla_pkg::tbl_cmd_type        cmd,
   input  wire logic [$clog2(SLOTS)-1:0]    wr_addr,
   input  wire logic [3:0]                  wr_kind,
   input  wire logic [31:0]                 wr_min,
   input  wire logic [31:0]                 wr_max,
   input  wire logic [$clog2(SLOTS)-1:0]    rd_addr,
   output qla_pkg::tbl_rd_type              rd_data,
   input  wire logic [$clog2(SLOTS)-1:0]    chk_addr,
   output logic                             chk_used
);

   import qla_pkg::*;

   logic [SLOTS-1:0] used_ff;
   logic [3:0]       kind_mem [SLOTS];
   logic [31:0]      min_mem  [SLOTS];
   logic [31:0]      max_mem  [SLOTS];
   tbl_rd_type       rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.add) begin
         used_ff[wr_addr] <= 1'b1;
      end else if (cmd.free) begin
         used_ff[wr_addr] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add) begin
         kind_mem[wr_addr] <= wr_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add || cmd.set_min) begin
         min_mem[wr_addr] <= wr_min;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add || cmd.set_max) begin
         max_mem[wr_addr] <= wr_max;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff.used    <= used_ff[rd_addr];
      rd_data_ff.kind    <= kind_mem[rd_addr];
      rd_data_ff.min_val <= min_mem[rd_addr];
      rd_data_ff.max_val <= max_mem[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign chk_used = used_ff[chk_addr];

   // A slot is never added and freed in the same cycle.
   assert property (@(posedge clock) disable iff (reset) !(cmd.add && cmd.free))
      else $error("table add and free in the same cycle");

   // After an add the slot reads as used.
   assert property (@(posedge clock) disable iff (reset)
      cmd.add |=> used_ff[$past(wr_addr)])
      else $error("added slot not marked used");

   // A limit is only rewritten in a slot that is in use.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.set_min || cmd.set_max) |-> used_ff[wr_addr])
      else $error("limit written to a free slot");

endmodule

`default_nettype wire

[design/qos_limit_aggregator.sv]
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  qla_pkg::req_item_type
// rsp_      out        rsp_valid/rsp_stall  qla_pkg::rsp_item_type
// csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One item is taken at a time; req_stall stays high until its result is in the output register.
// Add and rejected items go from decode to finish; the others write a limit, read the kind,
// scan with one table read per slot through the shared comparator and clamp; remove does both.
// The output register lets a new item enter while the previous result waits on rsp_stall.
// Reset is synchronous and clears the used bits; slot contents are written by add before use.
`default_nettype none

module qos_limit_aggregator #(
   parameter int SLOTS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire qla_pkg::req_item_type                 req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output qla_pkg::rsp_item_type                      rsp_data,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [qla_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [31:0]                           csr_wdata
);

   import qla_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_EXEC   = 7'b0000010,
      ST_WRITE  = 7'b0000100,
      ST_KIND   = 7'b0001000,
      ST_SCAN   = 7'b0010000,
      ST_CLAMP  = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type    state_ff, state_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;
   logic [31:0]  min_default_ff, max_default_ff;
   logic [31:0]  floor_ff, floor_in;
   logic [31:0]  ceiling_ff, ceiling_in;
   logic [31:0]  last_qos_ff, last_qos_in;

   logic [1:0]        cmd_ff, cmd_in;
   logic [3:0]        slot_ff, slot_in;
   logic [3:0]        new_kind_ff, new_kind_in;
   logic [31:0]       val_ff, val_in;
   logic [1:0]        status_ff, status_in;
   logic              phase_max_ff, phase_max_in;
   logic [SLOT_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [31:0]       best_ff, best_in;
   logic [3:0]        own_kind_ff, own_kind_in;

   tbl_cmd_type       tbl_cmd;
   logic [31:0]       tbl_wr_min, tbl_wr_max, upd_val;
   logic [SLOT_W-1:0] tbl_rd_addr, slot_idx;
   tbl_rd_type        tbl_rd;
   logic              chk_used, in_range, match;

   logic [31:0] unit_a, unit_b, unit_lesser;
   logic        unit_lt;

   assign slot_idx  = SLOT_W'(slot_ff);
   assign in_range  = ({28'd0, slot_ff} < 32'(SLOTS));
   assign upd_val   = (cmd_ff == CMD_REMOVE) ? (phase_max_ff ? max_default_ff : min_default_ff)
                                             : val_ff;
   assign match     = tbl_rd.used && (tbl_rd.kind == own_kind_ff);

   qla_table #(.SLOTS(SLOTS)) u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (tbl_cmd),
      .wr_addr  (slot_idx),
      .wr_kind  (new_kind_ff),
      .wr_min   (tbl_wr_min),
      .wr_max   (tbl_wr_max),
      .rd_addr  (tbl_rd_addr),
      .rd_data  (tbl_rd),
      .chk_addr (slot_idx),
      .chk_used (chk_used)
   );

   qla_minmax u_minmax (
      .a      (unit_a),
      .b      (unit_b),
      .a_lt_b (unit_lt),
      .lesser (unit_lesser)
   );

   always_comb begin
      if (state_ff == ST_CLAMP) begin
         unit_a = phase_max_ff ? floor_ff : ceiling_ff;
         unit_b = best_ff;
      end else if (phase_max_ff) begin
         unit_a = tbl_rd.max_val;
         unit_b = best_ff;
      end else begin
         unit_a = best_ff;
         unit_b = tbl_rd.min_val;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      floor_in     = floor_ff;
      ceiling_in   = ceiling_ff;
      last_qos_in  = last_qos_ff;
      cmd_in       = cmd_ff;
      slot_in      = slot_ff;
      new_kind_in  = new_kind_ff;
      val_in       = val_ff;
      status_in    = status_ff;
      phase_max_in = phase_max_ff;
      cmp_idx_in   = cmp_idx_ff;
      best_in      = best_ff;
      own_kind_in  = own_kind_ff;
      tbl_cmd      = '0;
      tbl_wr_min   = min_default_ff;
      tbl_wr_max   = max_default_ff;
      tbl_rd_addr  = slot_idx;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in      = req_data.cmd;
               slot_in     = req_data.slot;
               new_kind_in = req_data.req_type;
               val_in      = req_data.limit_value;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            status_in = STATUS_OK;
            state_in  = ST_FINISH;
            if (!in_range) begin
               status_in = STATUS_FREE;
            end else if (cmd_ff == CMD_ADD) begin
               if (chk_used) begin
                  status_in = STATUS_DUP;
               end else begin
                  tbl_cmd.add = 1'b1;
               end
            end else if (!chk_used) begin
               status_in = STATUS_FREE;
            end else begin
               phase_max_in = (cmd_ff == CMD_SETMAX);
               state_in     = ST_WRITE;
            end
         end
         ST_WRITE: begin
            tbl_cmd.set_min = !phase_max_ff;
            tbl_cmd.set_max = phase_max_ff;
            tbl_wr_min      = upd_val;
            tbl_wr_max      = upd_val;
            state_in        = ST_KIND;
         end
         ST_KIND: begin
            own_kind_in = tbl_rd.kind;
            tbl_rd_addr = '0;
            cmp_idx_in  = '0;
            best_in     = phase_max_ff ? U32_MAX : 32'd0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (match && unit_lt) begin
               best_in = phase_max_ff ? tbl_rd.max_val : tbl_rd.min_val;
            end
            if (cmp_idx_ff == LAST_SLOT) begin
               tbl_rd_addr = '0;
               state_in    = ST_CLAMP;
            end else begin
               cmp_idx_in  = cmp_idx_ff + 1'b1;
               tbl_rd_addr = cmp_idx_ff + 1'b1;
            end
         end
         ST_CLAMP: begin
            last_qos_in = unit_lesser;
            if (phase_max_ff) begin
               ceiling_in = best_ff;
            end else begin
               floor_in = best_ff;
            end
            if (cmd_ff == CMD_REMOVE && !phase_max_ff) begin
               phase_max_in = 1'b1;
               state_in     = ST_WRITE;
            end else begin
               tbl_cmd.free = (cmd_ff == CMD_REMOVE);
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.agg_value   = last_qos_ff;
               rsp_data_in.floor_now   = floor_ff;
               rsp_data_in.ceiling_now = ceiling_ff;
               rsp_data_in.status      = status_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         floor_ff       <= '0;
         ceiling_ff     <= U32_MAX;
         last_qos_ff    <= '0;
         min_default_ff <= '0;
         max_default_ff <= U32_MAX;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         floor_ff     <= floor_in;
         ceiling_ff   <= ceiling_in;
         last_qos_ff  <= last_qos_in;
         if (csr_valid && csr_ready && csr_index == CSR_MIN_DEFAULT) begin
            min_default_ff <= csr_wdata;
         end
         if (csr_valid && csr_ready && csr_index == CSR_MAX_DEFAULT) begin
            max_default_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      cmd_ff       <= cmd_in;
      slot_ff      <= slot_in;
      new_kind_ff  <= new_kind_in;
      val_ff       <= val_in;
      status_ff    <= status_in;
      phase_max_ff <= phase_max_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_ff      <= best_in;
      own_kind_ff  <= own_kind_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // An accepted item is always decoded in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_EXEC)
      else $error("accepted item not decoded");

   // A new result only appears after the finishing step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result loaded outside the finishing step");

   // After aggregation the reported value lies at or below both the floor and the ceiling.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLAMP |=> last_qos_ff <= floor_ff && last_qos_ff <= ceiling_ff)
      else $error("aggregated value exceeds floor or ceiling");

endmodule

`default_nettype wire
